FILE: hdl/bmf_pkg.sv
// Shared types for the box mean filter: request and result payloads,
// register indexes and the controller state codes. No dependencies.
`default_nettype none
package bmf_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;

  typedef struct packed {
    logic       action;
    logic [7:0] pixel;
  } bmf_req_t;

  typedef struct packed {
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic [7:0] mean_value;
    logic       frame_last;
  } bmf_res_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_HALF_WIDTH    = 3'd2,
    REG_HALF_HEIGHT   = 3'd3,
    REG_ROI_ROW_FIRST = 3'd4,
    REG_ROI_COL_FIRST = 3'd5,
    REG_ROI_ROW_LAST  = 3'd6,
    REG_ROI_COL_LAST  = 3'd7
  } bmf_reg_t;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_LATCH   = 12'b0000_0000_0010,
    S_PROD    = 12'b0000_0000_0100,
    S_WRITE   = 12'b0000_0000_1000,
    S_CENTRE  = 12'b0000_0001_0000,
    S_SETUP   = 12'b0000_0010_0000,
    S_ADDR    = 12'b0000_0100_0000,
    S_READ    = 12'b0000_1000_0000,
    S_LASTACC = 12'b0001_0000_0000,
    S_DSTART  = 12'b0010_0000_0000,
    S_DIV     = 12'b0100_0000_0000,
    S_EMIT    = 12'b1000_0000_0000
  } bmf_state_t;

endpackage
`default_nettype wire

FILE: hdl/box_mean_filter_unit.sv
// Box mean filter top level: configuration registers, frame controller,
// window read sequencer. Uses bmf_pkg, bmf_ram and bmf_div.
//
// Usage:
//  - Write the eight registers through cfg_we/cfg_index/cfg_data while idle;
//    they are latched when the first pixel of a frame is taken.
//  - Send pixels in raster order on the request channel (action 0), then
//    drain ticks (action 1) after the last pixel until frame_last shows.
//  - Each request yields zero or one result. Requests are handled one at a
//    time: a pixel is written to the pixel store and, once past the lag,
//    steps over one centre; a centre outside the region yields no result.
//    The first pixel of a frame also latches the configuration. For a
//    result the window is read from the pixel store one sample per cycle
//    through its single read port, then divided one quotient bit per cycle
//    (SUMW = 16 at default parameters).
//  - Results lag the pixel stream by half_height rows plus half_width pixels.
//  - The result sits in an output register: a new request is taken while it
//    waits, and the controller holds a following result until the receiver
//    takes the previous one.
//  - Reset (rst, synchronous) clears the counters and flags and restores the
//    register defaults. The pixel store needs no clearing: every sample read
//    belongs to the current frame.
`default_nettype none
module box_mean_filter_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_HALF   = 7
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [bmf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [bmf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               req_valid,
  output logic                                    req_ready,
  input  wire bmf_pkg::bmf_req_t                  req_data,
  output logic                                    res_valid,
  input  wire logic                               res_ready,
  output bmf_pkg::bmf_res_t                       res_data
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HTW   = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = (WW > 11) ? WW + 1 : 12;
  localparam int YW    = (HTW > 11) ? HTW + 1 : 12;
  localparam int HBW   = $clog2(MAX_HALF + 1);
  localparam int NBW   = $clog2(2 * MAX_HALF + 2);
  localparam int DEPTH = (2 * MAX_HALF + 1) * MAX_WIDTH + 2 * MAX_HALF + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int MW    = (TW > AW) ? TW : AW;
  localparam int CNTW  = 2 * NBW;
  localparam int SUMW  = $clog2((2 * MAX_HALF + 1) * (2 * MAX_HALF + 1) * 255 + 1);

  // configuration registers
  logic [10:0] reg_w, reg_h;
  logic [2:0]  reg_hw, reg_hh;
  logic [9:0]  reg_r0, reg_c0, reg_r1, reg_c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_w  <= 11'd1024;
      reg_h  <= 11'd1024;
      reg_hw <= 3'd1;
      reg_hh <= 3'd1;
      reg_r0 <= 10'd0;
      reg_c0 <= 10'd0;
      reg_r1 <= 10'd1023;
      reg_c1 <= 10'd1023;
    end else if (cfg_we) begin
      case (bmf_pkg::bmf_reg_t'(cfg_index))
        bmf_pkg::REG_IMAGE_WIDTH:   reg_w  <= cfg_data;
        bmf_pkg::REG_IMAGE_HEIGHT:  reg_h  <= cfg_data;
        bmf_pkg::REG_HALF_WIDTH:    reg_hw <= cfg_data[2:0];
        bmf_pkg::REG_HALF_HEIGHT:   reg_hh <= cfg_data[2:0];
        bmf_pkg::REG_ROI_ROW_FIRST: reg_r0 <= cfg_data[9:0];
        bmf_pkg::REG_ROI_COL_FIRST: reg_c0 <= cfg_data[9:0];
        bmf_pkg::REG_ROI_ROW_LAST:  reg_r1 <= cfg_data[9:0];
        bmf_pkg::REG_ROI_COL_LAST:  reg_c1 <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // frame configuration, latched at frame start
  logic [WW-1:0]  f_w;
  logic [HTW-1:0] f_h;
  logic [HBW-1:0] f_hw, f_hh;
  logic [YW-1:0]  f_r0, f_r1;
  logic [XW-1:0]  f_c0, f_c1;
  logic [TW-1:0]  f_total;
  logic [MW-1:0]  f_lag;

  bmf_pkg::bmf_state_t state;

  // frame progress
  logic          frame_done;
  logic [TW-1:0] pix_cnt, ctr_cnt;
  logic [AW-1:0] wp, cp;
  logic [YW-1:0] crow;
  logic [XW-1:0] ccol;
  logic [7:0]    pix_hold;

  // current centre work
  logic [YW-1:0]   wr_r;
  logic [XW-1:0]   wr_c;
  logic [AW-1:0]   base;
  logic            last_hit;
  logic [HBW-1:0]  dr, dc;
  logic [NBW-1:0]  nr, nc, ri, ci;
  logic [CNTW-1:0] cnt;
  logic [AW-1:0]   rd_addr, row_start;
  logic            rd_pend;
  logic [SUMW-1:0] sum;
  logic [7:0]      mean;

  logic [7:0]      ram_rdata;
  logic            div_done;
  logic [SUMW-1:0] div_quo;

  // combinational helpers
  logic [XW-1:0]  w_ext, h_ext;
  logic [TW-1:0]  pc_inc, cc_inc;
  logic [AW-1:0]  wp_inc, cp_inc, rd_inc;
  logic [AW:0]    rs_sum;
  logic [AW-1:0]  rs_next;
  logic [AW-1:0]  off;
  logic [AW:0]    tl_wrap;
  logic [AW-1:0]  tl;
  logic [YW-1:0]  r_hi, r_top, r_bot, r_lim;
  logic [XW-1:0]  c_hi, c_lft, c_rgt, c_lim;
  logic           in_roi;

  assign w_ext  = XW'(reg_w);
  assign h_ext  = XW'(reg_h);
  assign pc_inc = pix_cnt + TW'(1);
  assign cc_inc = ctr_cnt + TW'(1);
  assign wp_inc = (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
  assign cp_inc = (cp == AW'(DEPTH - 1)) ? '0 : cp + AW'(1);
  assign rd_inc = (rd_addr == AW'(DEPTH - 1)) ? '0 : rd_addr + AW'(1);
  assign rs_sum = {1'b0, row_start} + (AW+1)'(f_w);
  assign rs_next = (rs_sum >= (AW+1)'(DEPTH)) ? AW'(rs_sum - (AW+1)'(DEPTH)) : AW'(rs_sum);
  assign off     = AW'(dr) * AW'(f_w) + AW'(dc);
  assign tl_wrap = {1'b0, base} + (AW+1)'(DEPTH) - {1'b0, off};
  assign tl      = (base >= off) ? base - off : AW'(tl_wrap);

  // clipped window bounds around the centre
  assign r_hi  = wr_r + YW'(f_hh);
  assign r_lim = YW'(f_h) - YW'(1);
  assign r_top = (wr_r > YW'(f_hh)) ? wr_r - YW'(f_hh) : '0;
  assign r_bot = (r_hi > r_lim) ? r_lim : r_hi;
  assign c_hi  = wr_c + XW'(f_hw);
  assign c_lim = XW'(f_w) - XW'(1);
  assign c_lft = (wr_c > XW'(f_hw)) ? wr_c - XW'(f_hw) : '0;
  assign c_rgt = (c_hi > c_lim) ? c_lim : c_hi;

  assign in_roi = (crow >= f_r0) && (crow <= f_r1) && (ccol >= f_c0) && (ccol <= f_c1);

  assign req_ready = (state == bmf_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bmf_pkg::S_IDLE;
      frame_done <= 1'b0;
      pix_cnt    <= '0;
      ctr_cnt    <= '0;
      wp         <= '0;
      cp         <= '0;
      crow       <= '0;
      ccol       <= '0;
      rd_pend    <= 1'b0;
      res_valid  <= 1'b0;
      f_w        <= WW'(1);
      f_total    <= TW'(1);
    end else begin
      rd_pend <= (state == bmf_pkg::S_READ);
      // drop the result once taken; the emit state refills the register itself
      if (res_valid && res_ready && (state != bmf_pkg::S_EMIT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        bmf_pkg::S_IDLE: begin
          if (req_valid) begin
            pix_hold <= req_data.pixel;
            if (frame_done) begin
              state <= bmf_pkg::S_CENTRE;
            end else if (!req_data.action) begin
              state <= (pix_cnt == '0) ? bmf_pkg::S_LATCH : bmf_pkg::S_WRITE;
            end
          end
        end
        bmf_pkg::S_LATCH: begin
          // saturate the sizes
          f_w <= (w_ext == '0) ? WW'(1) :
                 (w_ext > XW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_ext);
          f_h <= (h_ext == '0) ? HTW'(1) :
                 (h_ext > XW'(MAX_HEIGHT)) ? HTW'(MAX_HEIGHT) : HTW'(h_ext);
          f_hw <= (int'(reg_hw) > MAX_HALF) ? HBW'(MAX_HALF) : HBW'(reg_hw);
          f_hh <= (int'(reg_hh) > MAX_HALF) ? HBW'(MAX_HALF) : HBW'(reg_hh);
          state <= bmf_pkg::S_PROD;
        end
        bmf_pkg::S_PROD: begin
          // widen the region of interest and clamp it to the image
          f_r0 <= (YW'(reg_r0) > YW'(f_hh)) ? YW'(reg_r0) - YW'(f_hh) : '0;
          f_c0 <= (XW'(reg_c0) > XW'(f_hw)) ? XW'(reg_c0) - XW'(f_hw) : '0;
          f_r1 <= (YW'(reg_r1) + YW'(f_hh) > YW'(f_h) - YW'(1)) ?
                  YW'(f_h) - YW'(1) : YW'(reg_r1) + YW'(f_hh);
          f_c1 <= (XW'(reg_c1) + XW'(f_hw) > XW'(f_w) - XW'(1)) ?
                  XW'(f_w) - XW'(1) : XW'(reg_c1) + XW'(f_hw);
          f_total <= TW'(f_w) * TW'(f_h);
          f_lag   <= MW'(f_hh) * MW'(f_w) + MW'(f_hw);
          state   <= bmf_pkg::S_WRITE;
        end
        bmf_pkg::S_WRITE: begin
          // the last pixel closes the frame; a pixel past the lag also steps a centre
          pix_cnt <= pc_inc;
          wp      <= wp_inc;
          if (pc_inc >= f_total) begin
            frame_done <= 1'b1;
          end
          if (MW'(pc_inc) > f_lag) begin
            state <= bmf_pkg::S_CENTRE;
          end else begin
            state <= bmf_pkg::S_IDLE;
          end
        end
        bmf_pkg::S_CENTRE: begin
          wr_r     <= crow;
          wr_c     <= ccol;
          base     <= cp;
          last_hit <= (crow == f_r1) && (ccol == f_c1);
          if (frame_done && (cc_inc >= f_total)) begin
            // end the frame when no centre is left
            frame_done <= 1'b0;
            pix_cnt    <= '0;
            ctr_cnt    <= '0;
            wp         <= '0;
            cp         <= '0;
            crow       <= '0;
            ccol       <= '0;
          end else begin
            // advance to the next centre
            ctr_cnt <= cc_inc;
            cp      <= cp_inc;
            if (ccol == XW'(f_w) - XW'(1)) begin
              ccol <= '0;
              crow <= crow + YW'(1);
            end else begin
              ccol <= ccol + XW'(1);
            end
          end
          state <= in_roi ? bmf_pkg::S_SETUP : bmf_pkg::S_IDLE;
        end
        bmf_pkg::S_SETUP: begin
          dr    <= HBW'(wr_r - r_top);
          dc    <= HBW'(wr_c - c_lft);
          nr    <= NBW'(r_bot - r_top + YW'(1));
          nc    <= NBW'(c_rgt - c_lft + XW'(1));
          state <= bmf_pkg::S_ADDR;
        end
        bmf_pkg::S_ADDR: begin
          cnt       <= CNTW'(nr) * CNTW'(nc);
          rd_addr   <= tl;
          row_start <= tl;
          ri        <= '0;
          ci        <= '0;
          sum       <= '0;
          state     <= bmf_pkg::S_READ;
        end
        bmf_pkg::S_READ: begin
          if (rd_pend) begin
            sum <= sum + SUMW'(ram_rdata);
          end
          if (ci == nc - NBW'(1)) begin
            ci        <= '0;
            ri        <= ri + NBW'(1);
            row_start <= rs_next;
            rd_addr   <= rs_next;
            if (ri == nr - NBW'(1)) begin
              state <= bmf_pkg::S_LASTACC;
            end
          end else begin
            ci      <= ci + NBW'(1);
            rd_addr <= rd_inc;
          end
        end
        bmf_pkg::S_LASTACC: begin
          sum   <= sum + SUMW'(ram_rdata);
          state <= bmf_pkg::S_DSTART;
        end
        bmf_pkg::S_DSTART: begin
          state <= bmf_pkg::S_DIV;
        end
        bmf_pkg::S_DIV: begin
          if (div_done) begin
            mean  <= div_quo[7:0];
            state <= bmf_pkg::S_EMIT;
          end
        end
        bmf_pkg::S_EMIT: begin
          // hold until the output register is free
          if (!res_valid || res_ready) begin
            res_valid           <= 1'b1;
            res_data.out_row    <= wr_r[9:0];
            res_data.out_col    <= wr_c[9:0];
            res_data.mean_value <= mean;
            res_data.frame_last <= last_hit;
            state               <= bmf_pkg::S_IDLE;
          end
        end
        default: state <= bmf_pkg::S_IDLE;
      endcase
    end
  end

  bmf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_pixel_store (
    .clk  (clk),
    .we   (state == bmf_pkg::S_WRITE),
    .waddr(wp),
    .wdata(pix_hold),
    .re   (state == bmf_pkg::S_READ),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  bmf_div #(
    .NW(SUMW),
    .DW(CNTW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(state == bmf_pkg::S_DSTART),
    .num  (sum),
    .den  (cnt),
    .done (div_done),
    .quo  (div_quo)
  );

  a_done_full: assert property (@(posedge clk) disable iff (rst)
    frame_done |-> pix_cnt >= f_total)
    else $error("frame done before all pixels arrived");

  a_centre_behind: assert property (@(posedge clk) disable iff (rst)
    ctr_cnt <= pix_cnt)
    else $error("centre counter ahead of pixel counter");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    ccol < XW'(f_w))
    else $error("centre column beyond row width");

  a_div_den: assert property (@(posedge clk) disable iff (rst)
    state == bmf_pkg::S_DSTART |-> cnt != '0)
    else $error("divide by zero window count");

endmodule
`default_nettype wire

FILE: hdl/bmf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module bmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bmf_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module bmf_div #(
  parameter int NW = 16,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic      [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cntr;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, quo[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cntr <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cntr <= CW'(NW);
      end else if (busy) begin
        cntr <= cntr - CW'(1);
        if (cntr == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem <= fits ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      quo <= {quo[NW-2:0], fits};
    end
  end

endmodule
`default_nettype wire
